[design/ael_pkg.sv]
// ----------------------------------------------------------------------------
// ael_pkg: shared types and constants of the arithmetic expression lexer
// Token kind codes, byte class codes, the queue entry layout and the
// single-character token lookup used by the front unit.
// ----------------------------------------------------------------------------
package ael_pkg;

   // Default width of the position cursor.
   localparam int DEFAULT_POSITION_BITS = 16;

   // Entries in the queue between the front and back units.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   // Token kind codes on the result channel.
   localparam logic [3:0] KIND_EOF        = 4'd0;
   localparam logic [3:0] KIND_NUMBER     = 4'd1;
   localparam logic [3:0] KIND_WHITESPACE = 4'd2;
   localparam logic [3:0] KIND_PLUS       = 4'd3;
   localparam logic [3:0] KIND_MINUS      = 4'd4;
   localparam logic [3:0] KIND_STAR       = 4'd5;
   localparam logic [3:0] KIND_SLASH      = 4'd6;
   localparam logic [3:0] KIND_LPAREN     = 4'd7;
   localparam logic [3:0] KIND_RPAREN     = 4'd8;
   localparam logic [3:0] KIND_INVALID    = 4'd9;

   // Open run codes held by the back unit.
   localparam logic [1:0] RUN_NONE   = 2'd0;
   localparam logic [1:0] RUN_NUMBER = 2'd1;
   localparam logic [1:0] RUN_BLANK  = 2'd2;

   // Byte classes decided by the front unit.
   localparam logic [1:0] CLS_END    = 2'd0;
   localparam logic [1:0] CLS_DIGIT  = 2'd1;
   localparam logic [1:0] CLS_BLANK  = 2'd2;
   localparam logic [1:0] CLS_SINGLE = 2'd3;

   // Character codes.
   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_LPAREN = 8'h28;
   localparam logic [7:0] CHAR_RPAREN = 8'h29;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;

   // Saturation limits.
   localparam logic [15:0] LENGTH_MAX = 16'hFFFF;
   localparam logic [30:0] VALUE_MAX  = 31'h7FFF_FFFF;

   // One classified byte as it travels from the front unit to the back unit.
   typedef struct packed {
      logic [1:0]  cls;
      logic [3:0]  kind;
      logic [7:0]  char_code;
      logic [15:0] pos;
   } entry_type;

   // Queue status seen by both sides.
   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   // Kind of a byte that forms a token of its own.
   function automatic logic [3:0] single_kind(input logic [7:0] c);
      logic [3:0] k;
      case (c)
         CHAR_PLUS:   k = KIND_PLUS;
         CHAR_MINUS:  k = KIND_MINUS;
         CHAR_STAR:   k = KIND_STAR;
         CHAR_SLASH:  k = KIND_SLASH;
         CHAR_LPAREN: k = KIND_LPAREN;
         CHAR_RPAREN: k = KIND_RPAREN;
         default:     k = KIND_INVALID;
      endcase
      return k;
   endfunction

endpackage

[design/ael_front.sv]
// ----------------------------------------------------------------------------
// ael_front: input side of the lexer
// Holds the start position register and the position cursor, classifies
// each accepted byte and hands it to the queue with its position.
// ----------------------------------------------------------------------------
module ael_front #(
   parameter int POSITION_BITS = ael_pkg::DEFAULT_POSITION_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [15:0]         csr_write_data,
   input  logic                req_valid,
   input  logic [7:0]          req_text_byte,
   input  logic                req_end_of_text,
   input  ael_pkg::queue_status_type q_status,
   output logic                q_push,
   output ael_pkg::entry_type  q_push_data
);
   import ael_pkg::*;

   logic [15:0]              start_pos_ff;
   logic [POSITION_BITS-1:0] cursor_ff;
   logic [POSITION_BITS-1:0] cursor_in;
   logic                     fresh_ff;
   logic                     fresh_in;
   logic [POSITION_BITS-1:0] pos;
   logic                     is_end;

   // A transaction is taken whenever the queue has room.
   assign q_push = req_valid && !q_status.full;

   // A zero byte ends the text just like the end marker.
   assign is_end = req_end_of_text || (req_text_byte == CHAR_NUL);

   // The first byte of a text takes its position from the register.
   assign pos = fresh_ff ? POSITION_BITS'(start_pos_ff) : cursor_ff;

   // Classify the byte.
   always_comb begin
      q_push_data.char_code = req_text_byte;
      q_push_data.pos       = 16'(pos);
      q_push_data.kind      = single_kind(req_text_byte);
      if (is_end) begin
         q_push_data.cls = CLS_END;
      end else if (req_text_byte >= CHAR_ZERO && req_text_byte <= CHAR_NINE) begin
         q_push_data.cls = CLS_DIGIT;
      end else if (req_text_byte == CHAR_SPACE || req_text_byte == CHAR_TAB) begin
         q_push_data.cls = CLS_BLANK;
      end else begin
         q_push_data.cls = CLS_SINGLE;
      end
   end

   // Cursor advance and text start tracking.
   always_comb begin
      cursor_in = cursor_ff;
      fresh_in  = fresh_ff;
      if (q_push) begin
         if (is_end) begin
            fresh_in = 1'b1;
         end else begin
            cursor_in = pos + 1'b1;
            fresh_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_pos_ff <= '0;
         cursor_ff    <= '0;
         fresh_ff     <= 1'b1;
      end else begin
         if (csr_write_enable) begin
            start_pos_ff <= csr_write_data;
         end
         cursor_ff <= cursor_in;
         fresh_ff  <= fresh_in;
      end
   end

endmodule

[design/ael_queue.sv]
// ----------------------------------------------------------------------------
// ael_queue: short queue between the front and back units
// A small register file with read and write pointers and a fill count.
// ----------------------------------------------------------------------------
module ael_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  ael_pkg::entry_type        push_data,
   input  logic                      pop,
   output ael_pkg::entry_type        pop_data,
   output ael_pkg::queue_status_type status
);
   import ael_pkg::*;

   entry_type                 slots_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_BITS:0]   count_ff;
   logic [QUEUE_PTR_BITS:0]   count_in;

   assign status.full      = (count_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign status.not_empty = (count_ff != '0);
   assign pop_data         = slots_ff[rd_ptr_ff];

   // Fill count follows pushes and pops.
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[design/ael_back.sv]
// ----------------------------------------------------------------------------
// ael_back: token builder of the lexer
// Keeps the open run, takes classified bytes from the queue and writes
// tokens into the output register. A byte that closes a run and also makes
// a token of its own stays at the queue head until its own token is built.
// ----------------------------------------------------------------------------
module ael_back (
   input  logic               clock,
   input  logic               reset,
   input  ael_pkg::queue_status_type q_status,
   input  ael_pkg::entry_type q_pop_data,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [3:0]         rsp_token_kind,
   output logic [15:0]        rsp_token_start,
   output logic [15:0]        rsp_token_length,
   output logic [30:0]        rsp_number_value,
   output logic [7:0]         rsp_token_char,
   output logic               rsp_last_of_step
);
   import ael_pkg::*;

   // Open run state.
   logic [1:0]  run_kind_ff,  run_kind_in;
   logic [15:0] run_start_ff, run_start_in;
   logic [15:0] run_len_ff,   run_len_in;
   logic [30:0] run_val_ff,   run_val_in;

   // Output register.
   logic        out_valid_ff, out_valid_in;
   logic [3:0]  out_kind_ff,  out_kind_in;
   logic [15:0] out_start_ff, out_start_in;
   logic [15:0] out_len_ff,   out_len_in;
   logic [30:0] out_val_ff,   out_val_in;
   logic [7:0]  out_char_ff,  out_char_in;
   logic        out_last_ff,  out_last_in;

   logic        load_ok;
   logic        go;
   logic        emit;
   logic        is_end;
   logic [1:0]  want;
   logic        has_run;
   logic        need_close;
   logic        follow;
   logic [3:0]  digit;
   logic [34:0] val_next;
   logic [30:0] val_sat;
   logic [15:0] len_sat;

   assign load_ok = !out_valid_ff || !rsp_stall;
   assign go      = load_ok && q_status.not_empty;

   assign is_end  = (q_pop_data.cls == CLS_END);
   assign has_run = (run_kind_ff != RUN_NONE);
   assign digit   = q_pop_data.char_code[3:0];

   // Run kind that this byte belongs to.
   always_comb begin
      case (q_pop_data.cls)
         CLS_DIGIT: want = RUN_NUMBER;
         CLS_BLANK: want = RUN_BLANK;
         default:   want = RUN_NONE;
      endcase
   end

   assign need_close = has_run && (is_end || want != run_kind_ff);
   assign follow     = is_end || (want == RUN_NONE);

   // Decimal accumulate with saturation: value * 10 + digit.
   assign val_next = {1'b0, run_val_ff, 3'b000} + {3'b000, run_val_ff, 1'b0}
                   + {31'b0, digit};
   assign val_sat  = (val_next > {4'b0, VALUE_MAX}) ? VALUE_MAX : val_next[30:0];
   assign len_sat  = (run_len_ff == LENGTH_MAX) ? run_len_ff : run_len_ff + 1'b1;

   // Token building.
   always_comb begin
      run_kind_in  = run_kind_ff;
      run_start_in = run_start_ff;
      run_len_in   = run_len_ff;
      run_val_in   = run_val_ff;
      emit         = 1'b0;
      q_pop        = 1'b0;
      out_kind_in  = KIND_EOF;
      out_start_in = '0;
      out_len_in   = '0;
      out_val_in   = '0;
      out_char_in  = CHAR_NUL;
      out_last_in  = 1'b1;

      if (go) begin
         if (need_close) begin
            // Close the open run first.
            emit         = 1'b1;
            out_kind_in  = (run_kind_ff == RUN_NUMBER) ? KIND_NUMBER : KIND_WHITESPACE;
            out_start_in = run_start_ff;
            out_len_in   = run_len_ff;
            out_val_in   = (run_kind_ff == RUN_NUMBER) ? run_val_ff : '0;
            out_last_in  = !follow;
            run_kind_in  = RUN_NONE;
            if (!follow) begin
               // The byte opens a run of the other kind.
               q_pop        = 1'b1;
               run_kind_in  = want;
               run_start_in = q_pop_data.pos;
               run_len_in   = 16'd1;
               run_val_in   = (want == RUN_NUMBER) ? {27'b0, digit} : '0;
            end
         end else if (is_end) begin
            emit  = 1'b1;
            q_pop = 1'b1;
         end else if (want == RUN_NONE) begin
            emit         = 1'b1;
            q_pop        = 1'b1;
            out_kind_in  = q_pop_data.kind;
            out_start_in = q_pop_data.pos;
            out_len_in   = 16'd1;
            out_char_in  = q_pop_data.char_code;
         end else if (has_run) begin
            // Same kind: extend the run.
            q_pop      = 1'b1;
            run_len_in = len_sat;
            if (want == RUN_NUMBER) begin
               run_val_in = val_sat;
            end
         end else begin
            q_pop        = 1'b1;
            run_kind_in  = want;
            run_start_in = q_pop_data.pos;
            run_len_in   = 16'd1;
            run_val_in   = (want == RUN_NUMBER) ? {27'b0, digit} : '0;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load_ok) begin
         out_valid_in = emit;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_kind_ff  <= RUN_NONE;
         run_start_ff <= '0;
         run_len_ff   <= '0;
         run_val_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         run_kind_ff  <= run_kind_in;
         run_start_ff <= run_start_in;
         run_len_ff   <= run_len_in;
         run_val_ff   <= run_val_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Output payload loads only with a new token.
   always_ff @(posedge clock) begin
      if (emit) begin
         out_kind_ff  <= out_kind_in;
         out_start_ff <= out_start_in;
         out_len_ff   <= out_len_in;
         out_val_ff   <= out_val_in;
         out_char_ff  <= out_char_in;
         out_last_ff  <= out_last_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_token_kind   = out_kind_ff;
   assign rsp_token_start  = out_start_ff;
   assign rsp_token_length = out_len_ff;
   assign rsp_number_value = out_val_ff;
   assign rsp_token_char   = out_char_ff;
   assign rsp_last_of_step = out_last_ff;

endmodule

[design/arith_expr_lexer.sv]
// ----------------------------------------------------------------------------
// arith_expr_lexer: arithmetic expression tokenizer
// Turns a byte stream into number, whitespace, operator, parenthesis,
// invalid and end-of-file tokens.
// ----------------------------------------------------------------------------
// Usage:
//  The request channel (req_) carries one text byte or an end marker per
//  transaction; a zero byte also ends the text. The response channel (rsp_)
//  carries tokens; rsp_last_of_step marks the last token of a request.
//  A request yields zero, one or two tokens.
//  csr_write_data sets the position of the first byte of each text; it is
//  latched with csr_write_enable and used when that first byte arrives.
//  A token reaches rsp_ after its request passes the queue and the
//  output register. A number or blank run gives its token only when a later
//  request closes it. Throughput: one request per cycle while req_stall is
//  low. A request with two tokens holds the back unit until both are loaded,
//  since the output register takes one token per cycle unless stalled; a
//  four-entry queue absorbs that.
//  Reset clears the queue, the open run, the output register and sets the
//  start position to 0.
//  When rsp_stall is high the token waits in the output register; the
//  queue keeps taking requests until it is full, then req_stall rises.
// ----------------------------------------------------------------------------
module arith_expr_lexer #(
   parameter int POSITION_BITS = ael_pkg::DEFAULT_POSITION_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_text_byte,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_token_kind,
   output logic [15:0] rsp_token_start,
   output logic [15:0] rsp_token_length,
   output logic [30:0] rsp_number_value,
   output logic [7:0]  rsp_token_char,
   output logic        rsp_last_of_step
);
   import ael_pkg::*;

   queue_status_type q_status;
   entry_type        q_push_data;
   entry_type        q_pop_data;
   logic             q_push;
   logic             q_pop;

   assign req_stall = q_status.full;

   // Front unit: classification and position tracking.
   ael_front #(
      .POSITION_BITS(POSITION_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_text_byte    (req_text_byte),
      .req_end_of_text  (req_end_of_text),
      .q_status         (q_status),
      .q_push           (q_push),
      .q_push_data      (q_push_data)
   );

   // Queue between the two units.
   ael_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   // Back unit: runs and token output.
   ael_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .q_pop_data       (q_pop_data),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_start  (rsp_token_start),
      .rsp_token_length (rsp_token_length),
      .rsp_number_value (rsp_number_value),
      .rsp_token_char   (rsp_token_char),
      .rsp_last_of_step (rsp_last_of_step)
   );

   // The back unit never takes an entry from an empty queue.
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_status.not_empty)
      else $error("queue popped while empty");

   // No token is presented right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("token valid after reset");

   // An end-of-file token closes its request and carries no position.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == KIND_EOF |->
         rsp_last_of_step && rsp_token_start == 16'd0 && rsp_token_length == 16'd0)
      else $error("malformed end-of-file token");

   // A whitespace token never carries a value or a character.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == KIND_WHITESPACE |->
         rsp_number_value == 31'd0 && rsp_token_char == CHAR_NUL
         && rsp_token_length != 16'd0)
      else $error("malformed whitespace token");

endmodule
